// ===== rtl/core/rational_arith_unit_assert.svh =====
// Assertion macros shared by the rational arithmetic unit RTL.
// All checks sample on clk and stay quiet while rst_n is low.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and sizes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int WIDTH  = 32;               // operand field width
  localparam int WIDE_W = 2 * WIDTH;        // product and reduction width
  localparam int CNT_W  = $clog2(WIDE_W);   // iteration counter width

  // Opcodes
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_NEG = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_LE  = 4'd6;
  localparam logic [3:0] OP_GT  = 4'd7;
  localparam logic [3:0] OP_GE  = 4'd8;
  localparam logic [3:0] OP_EQ  = 4'd9;
  localparam logic [3:0] OP_NE  = 4'd10;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [3:0]              opcode;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_num;
    logic [WIDTH-2:0]        res_den;
    logic                    cmp_true;
    logic [1:0]              status;
  } rau_out_t;

  // Operands of the shared add/subtract unit
  typedef struct packed {
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
    logic              sub;
  } rau_as_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_COMB, S_SUM2,
    S_GINIT, S_GCD, S_DIVN, S_DIVD, S_FIN
  } rau_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// Unsigned magnitude multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_mul (
  input  wire logic                           clk,
  input  wire logic [rau_pkg::WIDTH-1:0]      a,
  input  wire logic [rau_pkg::WIDTH-1:0]      b,
  output logic      [2*rau_pkg::WIDTH-1:0]    prod_r
);
  import rau_pkg::*;

  // register the product
  always_ff @(posedge clk) begin
    prod_r <= WIDE_W'(a) * WIDE_W'(b);
  end

endmodule

`default_nettype wire

// ===== rtl/core/rau_addsub.sv =====
// ----------------------------------------------------------------------------
// rau_addsub
// Shared wide adder/subtractor with carry out (carry high: no borrow).
// ----------------------------------------------------------------------------
`default_nettype none

module rau_addsub (
  input  wire rau_pkg::rau_as_req_t           req,
  output logic [2*rau_pkg::WIDTH-1:0]         sum,
  output logic                                carry
);
  import rau_pkg::*;

  logic [WIDE_W:0]   full;
  logic [WIDE_W-1:0] b_op;

  // invert b and add one for subtraction
  always_comb begin
    b_op = req.sub ? ~req.b : req.b;
    full = {1'b0, req.a} + {1'b0, b_op} + {{WIDE_W{1'b0}}, req.sub};
    sum   = full[WIDE_W-1:0];
    carry = full[WIDE_W];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit
// Rational add/sub/mul/div/negate and compare with gcd reduction.
// ----------------------------------------------------------------------------
// One item at a time: raise start while busy is low. An item with a bad
// opcode, a zero denominator or a divide by zero answers on the next cycle.
// Comparisons answer from the cross products. Arithmetic runs the multiply
// states S_M1 to S_M4, then a binary gcd on the 64-bit products and two
// 64-step restoring divisions, all run through one shared 64-bit
// adder/subtractor, one step a cycle. A zero numerator skips the reduction.
// Each result shows on out_item for one cycle with out_valid high; the
// receiver cannot stall it, and busy drops as the result goes out.
`default_nettype none

module rational_arith_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rau_pkg::rau_in_t  in_item,
  output logic                   out_valid,
  output rau_pkg::rau_out_t      out_item
);
  import rau_pkg::*;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WIDE_W - 1);
  localparam logic [WIDE_W-1:0] POS_LIMIT = WIDE_W'((64'd1 << (WIDTH - 1)) - 64'd1);

  rau_state_t        state_r, state_nxt;
  logic [3:0]        op_r, op_nxt;
  logic              a_neg_r, a_neg_nxt, b_neg_r, b_neg_nxt;
  logic [WIDTH-1:0]  an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [WIDE_W-1:0] x_r, x_nxt, y_r, y_nxt, num_r, num_nxt, den_r, den_nxt;
  logic              num_neg_r, num_neg_nxt;
  logic [WIDE_W-1:0] u_r, u_nxt, v_r, v_nxt, g_r, g_nxt, rem_r, rem_nxt, q_r, q_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt, cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  rau_out_t          out_item_r, out_item_nxt;

  logic [WIDTH-1:0]  mul_a, mul_b;
  logic [WIDE_W-1:0] prod;
  rau_as_req_t       as_req;
  logic [WIDE_W-1:0] as_sum;
  logic              as_carry;

  logic              in_err;
  logic              y_neg;
  logic              xs, ys, eq, lt, cmp_hit;
  logic [WIDE_W-1:0] div_try;
  logic              q_bit;
  logic [WIDE_W-1:0] q_shift;
  logic [WIDTH-1:0]  num_lo;

  logic              err_take, err_out, ok_out, in_div;

  rau_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  rau_addsub u_addsub (
    .req   (as_req),
    .sum   (as_sum),
    .carry (as_carry)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Flag items that answer at once with an error
  always_comb begin
    in_err = (in_item.opcode > OP_NE) || (in_item.a_den == '0) ||
             ((in_item.opcode != OP_NEG) && (in_item.b_den == '0)) ||
             ((in_item.opcode == OP_DIV) && (in_item.b_num == '0));
  end

  // Select multiplier operands per phase
  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (state_r)
      S_M1: begin
        mul_a = an_r;
        if (op_r == OP_MUL)      mul_b = bn_r;
        else if (op_r == OP_NEG) mul_b = WIDTH'(1);
        else                     mul_b = bd_r;
      end
      S_M2: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      S_M3: begin
        mul_a = ad_r;
        if (op_r == OP_DIV)      mul_b = bn_r;
        else if (op_r == OP_NEG) mul_b = WIDTH'(1);
        else                     mul_b = bd_r;
      end
      default: begin
        mul_a = an_r;
        mul_b = bd_r;
      end
    endcase
  end

  // Select operands of the shared adder/subtractor
  always_comb begin
    y_neg   = b_neg_r ^ (op_r == OP_SUB);
    div_try = {rem_r[WIDE_W-2:0], q_r[WIDE_W-1]};
    as_req  = '{a: x_r, b: y_r, sub: 1'b1};
    case (state_r)
      S_COMB:  as_req = '{a: x_r, b: y_r,
                          sub: !(((op_r == OP_ADD) || (op_r == OP_SUB)) && (a_neg_r == y_neg))};
      S_SUM2:  as_req = '{a: y_r, b: x_r, sub: 1'b1};
      S_GCD:   as_req = '{a: u_r, b: v_r, sub: 1'b1};
      S_DIVN,
      S_DIVD:  as_req = '{a: div_try, b: g_r, sub: 1'b1};
      default: as_req = '{a: x_r, b: y_r, sub: 1'b1};
    endcase
  end

  // Compare cross products and one restoring division step
  always_comb begin
    xs = a_neg_r && (x_r != '0);
    ys = b_neg_r && (y_r != '0);
    eq = (xs == ys) && (as_sum == '0);
    if (xs != ys) lt = xs;
    else if (xs)  lt = !eq && as_carry;
    else          lt = !as_carry;
    case (op_r)
      OP_LT:   cmp_hit = lt;
      OP_LE:   cmp_hit = lt || eq;
      OP_GT:   cmp_hit = !lt && !eq;
      OP_GE:   cmp_hit = !lt;
      OP_EQ:   cmp_hit = eq;
      default: cmp_hit = !eq;
    endcase
    q_bit   = as_carry;
    q_shift = {q_r[WIDE_W-2:0], q_bit};
    num_lo  = num_r[WIDTH-1:0];
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    a_neg_nxt     = a_neg_r;
    b_neg_nxt     = b_neg_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    num_nxt       = num_r;
    num_neg_nxt   = num_neg_r;
    den_nxt       = den_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_err) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: ST_ERR};
          end else begin
            op_nxt    = in_item.opcode;
            an_nxt    = in_item.a_num[WIDTH-1] ? (~in_item.a_num + 1'b1) : in_item.a_num;
            ad_nxt    = in_item.a_den[WIDTH-1] ? (~in_item.a_den + 1'b1) : in_item.a_den;
            bn_nxt    = in_item.b_num[WIDTH-1] ? (~in_item.b_num + 1'b1) : in_item.b_num;
            bd_nxt    = in_item.b_den[WIDTH-1] ? (~in_item.b_den + 1'b1) : in_item.b_den;
            a_neg_nxt = in_item.a_num[WIDTH-1] ^ in_item.a_den[WIDTH-1];
            b_neg_nxt = in_item.b_num[WIDTH-1] ^ in_item.b_den[WIDTH-1];
            state_nxt = S_M1;
          end
        end
      end
      S_M1: state_nxt = S_M2;
      S_M2: begin
        x_nxt     = prod;
        state_nxt = S_M3;
      end
      S_M3: begin
        y_nxt     = prod;
        state_nxt = S_M4;
      end
      S_M4: begin
        den_nxt   = prod;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        if (op_r >= OP_LT) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{res_num: '0, res_den: (WIDTH-1)'(1), cmp_true: cmp_hit,
                            status: ST_OK};
          state_nxt     = S_IDLE;
        end else if ((op_r == OP_ADD) || (op_r == OP_SUB)) begin
          if (a_neg_r == y_neg) begin
            num_nxt     = as_sum;
            num_neg_nxt = a_neg_r;
            state_nxt   = S_GINIT;
          end else if (as_carry) begin
            num_nxt     = as_sum;
            num_neg_nxt = a_neg_r;
            state_nxt   = S_GINIT;
          end else begin
            state_nxt   = S_SUM2;
          end
        end else begin
          num_nxt     = x_r;
          num_neg_nxt = (op_r == OP_NEG) ? !a_neg_r : (a_neg_r ^ b_neg_r);
          state_nxt   = S_GINIT;
        end
      end
      S_SUM2: begin
        num_nxt     = as_sum;
        num_neg_nxt = y_neg;
        state_nxt   = S_GINIT;
      end
      S_GINIT: begin
        if (num_r == '0) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{res_num: '0, res_den: (WIDTH-1)'(1), cmp_true: 1'b0,
                            status: ST_OK};
          state_nxt     = S_IDLE;
        end else begin
          u_nxt     = num_r;
          v_nxt     = den_r;
          k_nxt     = '0;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        // binary gcd: halve evens, subtract odds, swap to keep u >= v
        if (u_r == '0) begin
          g_nxt     = v_r << k_r;
          rem_nxt   = '0;
          q_nxt     = num_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (!as_carry) begin
          u_nxt = v_r;
          v_nxt = u_r;
        end else begin
          u_nxt = as_sum >> 1;
        end
      end
      S_DIVN: begin
        rem_nxt = q_bit ? as_sum : div_try;
        q_nxt   = q_shift;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          num_nxt   = q_shift;
          rem_nxt   = '0;
          q_nxt     = den_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        rem_nxt = q_bit ? as_sum : div_try;
        q_nxt   = q_shift;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          den_nxt   = q_shift;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if ((den_r > POS_LIMIT) || (num_r > (POS_LIMIT + WIDE_W'(num_neg_r)))) begin
          out_item_nxt = '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: ST_OVF};
        end else begin
          out_item_nxt = '{res_num: num_neg_r ? (~num_lo + 1'b1) : num_lo,
                           res_den: den_r[WIDTH-2:0], cmp_true: 1'b0, status: ST_OK};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_neg_r    <= a_neg_nxt;
    b_neg_r    <= b_neg_nxt;
    an_r       <= an_nxt;
    ad_r       <= ad_nxt;
    bn_r       <= bn_nxt;
    bd_r       <= bd_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    num_r      <= num_nxt;
    num_neg_r  <= num_neg_nxt;
    den_r      <= den_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    g_r        <= g_nxt;
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  // Conditions watched by the checks below
  assign err_take = start && !busy && in_err;
  assign err_out  = out_valid && (out_item.status == ST_ERR);
  assign ok_out   = out_valid && (out_item.status == ST_OK);
  assign in_div   = (state_r == S_DIVN) || (state_r == S_DIVD);

`include "rational_arith_unit_assert.svh"

  `RAU_ASSERT_NEXT(a_err_fast, err_take, err_out, "bad item not rejected next cycle")
  `RAU_ASSERT_NOW(a_ok_den, ok_out, out_item.res_den != '0, "ok result with zero denominator")
  `RAU_ASSERT_NOW(a_gcd_v, state_r == S_GCD, v_r != '0, "gcd divisor went to zero")
  `RAU_ASSERT_NOW(a_div_g, in_div, g_r != '0, "divide by zero gcd")

endmodule

`default_nettype wire
